>>> rtl/sah_pkg.sv
// shared types for the set associative hash table
// command and status bundles between controller and datapath; no dependencies
package sah_pkg;

  localparam logic [63:0] HASH_SEED = 64'd5381;
  localparam int unsigned HASH_SHIFT = 5;
  localparam int unsigned MOD_STEPS = 8;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic hash_step;
    logic mod_step;
    logic mem_rd;
    logic upd;
  } sah_cmd_t;

  typedef struct packed {
    logic clr_last;
  } sah_status_t;

endpackage

>>> rtl/sah_ctrl.sv
// sequencing state machine for the set associative hash table
// uses sah_pkg command and status types; drives sah_dpath
module sah_ctrl import sah_pkg::*; #(
  parameter int NUM_BUCKETS = 256,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  sah_status_t status,
  output sah_cmd_t    cmd
);

  localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam logic [2:0] HASH_LAST = 3'(KEY_BYTES - 1);
  localparam logic [2:0] MOD_LAST = 3'(MOD_STEPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_MOD,
    S_READ,
    S_UPD
  } state_t;

  state_t     state;
  logic [2:0] cnt;

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_HASH: cmd.hash_step = 1'b1;
      S_MOD:  cmd.mod_step = 1'b1;
      S_READ: cmd.mem_rd = 1'b1;
      S_UPD:  cmd.upd = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.upd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (status.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (cnt == HASH_LAST) begin
            cnt <= '0;
            state <= IS_POW2 ? S_READ : S_MOD;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_MOD: begin
          if (cnt == MOD_LAST) begin
            cnt <= '0;
            state <= S_READ;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          if (cmd.upd) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/sah_dpath.sv
// datapath: hash register, bucket remainder unit, bucket store and result registers
// uses sah_pkg command and status types; controlled by sah_ctrl
module sah_dpath import sah_pkg::*; #(
  parameter int NUM_BUCKETS = 256,
  parameter int WAYS = 4,
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  sah_cmd_t    cmd,
  output sah_status_t status,
  input  logic        action,
  input  logic [63:0] key,
  input  logic [63:0] value,
  output logic        found,
  output logic        evicted,
  output logic [63:0] out_key,
  output logic [63:0] out_value
);

  localparam int KW = KEY_BYTES * 8;
  localparam int VW = VALUE_BYTES * 8;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int TW = BW + 8;
  localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

  logic [WAYS-1:0][KW-1:0] key_mem [NUM_BUCKETS];
  logic [WAYS-1:0][VW-1:0] val_mem [NUM_BUCKETS];

  logic [WAYS-1:0][KW-1:0] rd_key;
  logic [WAYS-1:0][VW-1:0] rd_val;
  logic [WAYS-1:0][KW-1:0] wr_key;
  logic [WAYS-1:0][VW-1:0] wr_val;

  logic          act_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] val_r;
  logic [KW-1:0] kshift;
  logic          hdone;
  logic [63:0]   hash;
  logic [BW-1:0] rem;
  logic [BW-1:0] rem_next;
  logic [BW-1:0] bucket;
  logic [BW-1:0] clr_addr;
  logic [BW-1:0] wr_addr;
  logic          wr_en;

  logic          found_next;
  logic          evicted_next;
  logic [KW-1:0] out_key_next;
  logic [VW-1:0] out_value_next;

  assign status.clr_last = (clr_addr == BW'(NUM_BUCKETS - 1));

  // one radix-256 digit of the remainder per step
  always_comb begin
    logic [TW-1:0] t;
    t = {rem, hash[63:56]};
    for (int j = MOD_STEPS - 1; j >= 0; j--) begin
      if (t >= (TW'(NUM_BUCKETS) << j)) t = t - (TW'(NUM_BUCKETS) << j);
    end
    rem_next = t[BW-1:0];
  end

  assign bucket = IS_POW2 ? hash[BW-1:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      key_r <= key[KW-1:0];
      val_r <= value[VW-1:0];
      kshift <= key[KW-1:0];
      hdone <= 1'b0;
      hash <= HASH_SEED;
      rem <= '0;
    end
    if (cmd.hash_step) begin
      if (kshift[7:0] == 8'd0) begin
        hdone <= 1'b1;
      end else if (!hdone) begin
        hash <= (hash << HASH_SHIFT) + hash + 64'(kshift[7:0]);
      end
      kshift <= kshift >> 8;
    end
    if (cmd.mod_step) begin
      rem <= rem_next;
      hash <= hash << 8;
    end
  end

  // bucket search and row update
  always_comb begin
    logic [WAYS-1:0] q_ins;
    logic [WAYS-1:0] q_lk;
    logic            seen_ins;
    logic            seen_lk;
    wr_key = rd_key;
    wr_val = rd_val;
    found_next = 1'b0;
    evicted_next = 1'b0;
    out_key_next = '0;
    out_value_next = '0;
    seen_ins = 1'b0;
    seen_lk = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      q_ins[w] = !seen_ins && ((rd_key[w] == key_r) || (rd_key[w][7:0] == 8'd0));
      q_lk[w] = !seen_lk && (rd_key[w] == key_r);
      seen_ins = seen_ins || q_ins[w];
      seen_lk = seen_lk || q_lk[w];
    end
    if (act_r == ACT_LOOKUP) begin
      found_next = seen_lk;
      for (int w = 0; w < WAYS; w++) begin
        if (q_lk[w]) out_value_next = rd_val[w];
      end
    end else if (seen_ins) begin
      found_next = 1'b1;
      for (int w = 0; w < WAYS; w++) begin
        if (q_ins[w]) begin
          wr_key[w] = key_r;
          wr_val[w] = val_r;
        end
      end
    end else begin
      // bucket full: drop the oldest way, shift down, append
      evicted_next = 1'b1;
      out_key_next = rd_key[0];
      out_value_next = rd_val[0];
      for (int w = 0; w < WAYS - 1; w++) begin
        wr_key[w] = rd_key[w+1];
        wr_val[w] = rd_val[w+1];
      end
      wr_key[WAYS-1] = key_r;
      wr_val[WAYS-1] = val_r;
    end
  end

  assign wr_en = cmd.clr_step || (cmd.upd && (act_r == ACT_INSERT));
  assign wr_addr = cmd.clr_step ? clr_addr : bucket;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= cmd.clr_step ? '0 : wr_key;
      val_mem[wr_addr] <= cmd.clr_step ? '0 : wr_val;
    end
    if (cmd.mem_rd) begin
      rd_key <= key_mem[bucket];
      rd_val <= val_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      found <= found_next;
      evicted <= evicted_next;
      out_key <= 64'(out_key_next);
      out_value <= 64'(out_value_next);
    end
  end

endmodule

>>> rtl/set_assoc_hash_table.sv
// top level of the set associative hash table
// instantiates sah_ctrl and sah_dpath; types from sah_pkg

// Set associative key/value store with per-bucket oldest-first replacement.
// Each item is an insert (action 0) or a lookup (action 1) and gives exactly
// one result item. The bucket is the djb2 hash of the key bytes (byte 0
// first, stopping at the first zero byte, 64-bit wrap) modulo NUM_BUCKETS.
// An insert lands in the first way whose key matches or whose first key byte
// is zero; if none does, way 0 is dropped and reported, the other ways move
// down, and the new pair takes the last way. After reset a clearing pass
// writes zero to every bucket row, one row a cycle, during which no item is
// taken. For each item the hash unit then folds in one key byte a cycle;
// when NUM_BUCKETS is not a power of two the remainder unit next reduces
// one hash byte a cycle. Then the bucket row is read, and last the ways are
// compared and the row is written back. The next item is taken in the idle
// state after that, so no item is taken while the one before it is still
// being worked on.
// A finished result sits in an output register, so the next item is taken
// while it waits to be read; that item stalls in its update cycle until the
// waiting result is read.
module set_assoc_hash_table import sah_pkg::*; #(
  parameter int NUM_BUCKETS = 256,
  parameter int WAYS = 4,
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [63:0] key,
  input  logic [63:0] value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic        evicted,
  output logic [63:0] out_key,
  output logic [63:0] out_value
);

  sah_cmd_t    cmd;
  sah_status_t status;

  // sequencer: clearing pass, hash, remainder, row read, row update
  sah_ctrl #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // hash, bucket store and result registers
  sah_dpath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .action    (action),
    .key       (key),
    .value     (value),
    .found     (found),
    .evicted   (evicted),
    .out_key   (out_key),
    .out_value (out_value)
  );

endmodule

>>> bench/set_assoc_hash_table_tb.sv
// self-checking bench for set_assoc_hash_table: queued stimulus, driver and monitor
// predicts every result from its own copy of the bucket store; uses sah_pkg
module set_assoc_hash_table_tb;
  import sah_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUCKETS = 256;
  localparam int WAYS = 4;
  localparam int STORE_DEPTH = NUM_BUCKETS * WAYS;
  localparam int RANDOM_ITEMS = 800;
  // sequence number of the item that waits for the table to go quiet
  localparam int DRAIN_AT = 430;
  // items in this window go back to back with no sender gaps
  localparam int BURST_LO = 130;
  localparam int BURST_HI = 210;
  // result count at which the receiver holds off for a long stretch
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;
  // results in this window are taken with no receiver stalls
  localparam int FLOW_LO = 500;
  localparam int FLOW_HI = 600;
  // longest correct quiet stretch is the post-reset clear or the long hold-off
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic        act;
    logic [63:0] key;
    logic [63:0] value;
  } request_t;

  typedef struct packed {
    logic        found;
    logic        evicted;
    logic [63:0] rkey;
    logic [63:0] rval;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_INSERT;
  logic [63:0] key = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic        evicted;
  logic [63:0] out_key;
  logic [63:0] out_value;

  // shadow copy of the bucket store, cleared like the block after reset
  logic [63:0] shadow_keys [STORE_DEPTH];
  logic [63:0] shadow_vals [STORE_DEPTH];

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  request_t offered;
  int       offer_index = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       requests_taken = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;

  set_assoc_hash_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS(WAYS),
    .KEY_BYTES(8),
    .VALUE_BYTES(8)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .evicted(evicted),
    .out_key(out_key),
    .out_value(out_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // djb2 over the key bytes, low byte first, stopping at the first zero byte
  function automatic int unsigned bucket_of_key(input logic [63:0] k);
    logic [63:0] h;
    bit          stopped;
    h = HASH_SEED;
    stopped = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (k[i*8 +: 8] == 8'd0) stopped = 1'b1;
      if (!stopped) h = (h << HASH_SHIFT) + h + 64'(k[i*8 +: 8]);
    end
    return int'(h % NUM_BUCKETS);
  endfunction

  // apply one request to the shadow store and return what the block should answer
  task automatic apply_request(input request_t r, output outcome_t o);
    int unsigned base;
    bit          done;
    base = bucket_of_key(r.key) * WAYS;
    o = '0;
    done = 1'b0;
    if (r.act == ACT_LOOKUP) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!done && shadow_keys[base + w] == r.key) begin
          o.found = 1'b1;
          o.rval = shadow_vals[base + w];
          done = 1'b1;
        end
      end
    end else begin
      // first way holding the same key or an empty first byte takes the pair
      for (int w = 0; w < WAYS; w++) begin
        if (!done && (shadow_keys[base + w] == r.key || shadow_keys[base + w][7:0] == 8'd0)) begin
          shadow_keys[base + w] = r.key;
          shadow_vals[base + w] = r.value;
          o.found = 1'b1;
          done = 1'b1;
        end
      end
      // bucket full: drop the oldest way, slide the rest down, append at the top
      if (!done) begin
        o.evicted = 1'b1;
        o.rkey = shadow_keys[base];
        o.rval = shadow_vals[base];
        for (int w = 0; w + 1 < WAYS; w++) begin
          shadow_keys[base + w] = shadow_keys[base + w + 1];
          shadow_vals[base + w] = shadow_vals[base + w + 1];
        end
        shadow_keys[base + WAYS - 1] = r.key;
        shadow_vals[base + WAYS - 1] = r.value;
      end
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return '1;
    return rand64();
  endfunction

  // random key that hashes into bucket b; some keys end early on a zero byte
  function automatic logic [63:0] key_in_bucket(input int unsigned b);
    logic [63:0] k;
    bit          hit;
    hit = 1'b0;
    while (!hit) begin
      k = rand64();
      if ($urandom_range(0, 3) == 0) k[$urandom_range(1, 7)*8 +: 8] = 8'd0;
      hit = (k[7:0] != 8'd0) && (bucket_of_key(k) == b);
    end
    return k;
  endfunction

  // sender gaps: mostly none or short, now and then long
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic add_item(input logic act, input logic [63:0] k, input logic [63:0] v);
    request_t r;
    r.act = act;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
  end

  // request side: offer queued items, predict each one as it is accepted
  always @(posedge clk) begin : drive_requests
    outcome_t o;
    int       gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      gap = gap_left;
      if (in_valid) begin
        apply_request(offered, o);
        expected_outcomes.push_back(o);
        requests_taken <= requests_taken + 1;
        gap = (offer_index >= BURST_LO && offer_index < BURST_HI) ? 0 : pick_gap();
      end
      if (gap > 0) begin
        gap_left = gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   (offer_index != DRAIN_AT ||
                    (!in_valid && requests_taken == results_seen))) begin
        // the drain item only goes out once every result has come back
        gap_left = 0;
        offered = pending_reqs.pop_front();
        offer_index = offer_index + 1;
        in_valid <= 1'b1;
        action <= offered.act;
        key <= offered.key;
        value <= offered.value;
      end else begin
        gap_left = 0;
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random back-pressure and field-by-field checking
  always @(posedge clk) begin : collect_results
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result item: found=%b evicted=%b key=%h value=%h",
                     found, evicted, out_key, out_value);
        end else begin
          want = expected_outcomes.pop_front();
          if (found !== want.found || evicted !== want.evicted ||
              out_key !== want.rkey || out_value !== want.rval) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected found=%b evicted=%b key=%h value=%h",
                       want.found, want.evicted, want.rkey, want.rval);
              $display("  actual   found=%b evicted=%b key=%h value=%h",
                       found, evicted, out_key, out_value);
            end
          end
        end
        // long hold-off lets the block fill up and push back on its input
        if (results_seen + 1 == HOLD_AT) stall_left = HOLD_CYCLES;
        else if (results_seen + 1 >= FLOW_LO && results_seen + 1 < FLOW_HI) stall_left = 0;
        else stall_left = pick_stall();
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // quiet-cycle watchdog: no item moving on either side for too long
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    logic [63:0]  fill [5];
    logic [63:0]  k;
    int unsigned  hot [8];
    int unsigned  b;
    int           pick;
    logic [63:0]  recent[$];

    // directed items
    b = $urandom_range(0, NUM_BUCKETS - 1);
    if (b == bucket_of_key(64'd0)) b = (b + 1) % NUM_BUCKETS;
    for (int i = 0; i < 5; i++) fill[i] = key_in_bucket(b);

    // zero key matches a never-written way and hits with value zero
    add_item(ACT_LOOKUP, 64'd0, rand64());
    add_item(ACT_INSERT, '1, '1);
    add_item(ACT_LOOKUP, '1, '0);
    // lookup miss in a bucket nothing has touched yet
    add_item(ACT_LOOKUP, fill[4], rand64());
    // zero first byte: hash covers nothing, lands in the seed bucket
    add_item(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 64'h0123_4567_89AB_CDEF);
    add_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, '0);
    add_item(ACT_LOOKUP, 64'd0, '0);
    // way 0 now looks empty again, so this key overwrites it
    add_item(ACT_INSERT, 64'h0000_0000_0000_1200, 64'hFEDC_BA98_7654_3210);
    add_item(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, '0);
    add_item(ACT_INSERT, 64'h0000_0000_0000_0001, '0);
    add_item(ACT_LOOKUP, 64'h0000_0000_0000_0001, '1);
    // fill one bucket, overwrite a way, then force evictions
    for (int i = 0; i < 4; i++) add_item(ACT_INSERT, fill[i], rand64());
    add_item(ACT_INSERT, fill[1], 64'h8000_0000_0000_0001);
    add_item(ACT_INSERT, fill[4], rand64());
    add_item(ACT_LOOKUP, fill[0], '0);
    add_item(ACT_LOOKUP, fill[4], '0);
    add_item(ACT_INSERT, fill[0], '1);
    add_item(ACT_LOOKUP, fill[2], '0);
    add_item(ACT_LOOKUP, fill[0], '0);
    add_item(ACT_INSERT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);

    // random part: a few hot buckets so ways fill and evict often
    hot[0] = bucket_of_key(64'd0);
    for (int i = 1; i < 8; i++) hot[i] = $urandom_range(0, NUM_BUCKETS - 1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        k = key_in_bucket(hot[$urandom_range(0, 7)]);
        add_item(ACT_INSERT, k, rand_value());
        recent.push_back(k);
        if (recent.size() > 64) void'(recent.pop_front());
      end else if (pick < 55 && recent.size() > 0) begin
        add_item(ACT_INSERT, recent[$urandom_range(0, recent.size() - 1)], rand_value());
      end else if (pick < 80 && recent.size() > 0) begin
        add_item(ACT_LOOKUP, recent[$urandom_range(0, recent.size() - 1)], rand64());
      end else if (pick < 88) begin
        add_item(ACT_LOOKUP, rand64(), rand64());
      end else if (pick < 93) begin
        k = rand64();
        k[7:0] = 8'd0;
        add_item($urandom_range(0, 1) ? ACT_LOOKUP : ACT_INSERT, k, rand_value());
      end else if (pick < 96) begin
        add_item(ACT_LOOKUP, 64'd0, rand64());
      end else begin
        add_item($urandom_range(0, 1) ? ACT_LOOKUP : ACT_INSERT, rand64(), rand_value());
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // all items sent and every expected result back
    while (pending_reqs.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> set_assoc_hash_table.f
rtl/sah_pkg.sv
rtl/sah_ctrl.sv
rtl/sah_dpath.sv
rtl/set_assoc_hash_table.sv
bench/set_assoc_hash_table_tb.sv
